@@ sv/tpic_pkg.sv @@
package tpic_pkg;

	localparam int CoordBits = 8;

	typedef struct packed {
		logic [CoordBits-1:0] first_x0;
		logic [CoordBits-1:0] first_y0;
		logic [CoordBits-1:0] first_x1;
		logic [CoordBits-1:0] first_y1;
		logic [CoordBits-1:0] first_x2;
		logic [CoordBits-1:0] first_y2;
		logic [CoordBits-1:0] second_x0;
		logic [CoordBits-1:0] second_y0;
		logic [CoordBits-1:0] second_x1;
		logic [CoordBits-1:0] second_y1;
		logic [CoordBits-1:0] second_x2;
		logic [CoordBits-1:0] second_y2;
	} tpic_in_t;

	typedef struct packed {
		logic meets;
		logic interiors_apart;
		logic common_vertex;
	} tpic_out_t;

	// sign of an orientation value
	typedef struct packed {
		logic pos;
		logic neg;
	} tpic_sign_t;

endpackage

@@ sv/tpic_orient.sv @@
// Orientation signs of all point/edge pairs, two register stages:
// stage 1 holds the edge and point differences, stage 2 the products.
module tpic_orient import tpic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  logic [CoordBits-1:0] px [6],
	input  logic [CoordBits-1:0] py [6],
	output logic                 vld_o,
	output tpic_sign_t           sgn [2][3][6],
	output logic                 shared
);

	localparam int DW = CoordBits + 1;
	localparam int PW = 2 * DW;
	localparam int OW = PW + 1;

	// edge e of triangle t: vertex 3t+e to vertex 3t+(e+1)%3, vs point p
	logic signed [DW-1:0] ex_s1 [6];
	logic signed [DW-1:0] ey_s1 [6];
	logic signed [DW-1:0] rx_s1 [6][6];
	logic signed [DW-1:0] ry_s1 [6][6];
	logic signed [PW-1:0] m0_s2 [6][6];
	logic signed [PW-1:0] m1_s2 [6][6];
	logic                 vld_s1, vld_s2, shared_s1, shared_s2;
	logic                 shared_d;

	// any vertex of the first triangle equal to one of the second
	always_comb begin
		shared_d = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 3; j < 6; j++)
				if (px[i] == px[j] && py[i] == py[j])
					shared_d = 1'b1;
	end

	// differences
	always_ff @(posedge clk) begin
		for (int e = 0; e < 6; e++) begin
			ex_s1[e] <= $signed({1'b0, px[(e/3)*3 + (e%3+1)%3]}) - $signed({1'b0, px[e]});
			ey_s1[e] <= $signed({1'b0, py[(e/3)*3 + (e%3+1)%3]}) - $signed({1'b0, py[e]});
			for (int p = 0; p < 6; p++) begin
				rx_s1[e][p] <= $signed({1'b0, px[p]}) - $signed({1'b0, px[e]});
				ry_s1[e][p] <= $signed({1'b0, py[p]}) - $signed({1'b0, py[e]});
			end
		end
		shared_s1 <= shared_d;
	end

	// products
	always_ff @(posedge clk) begin
		for (int e = 0; e < 6; e++)
			for (int p = 0; p < 6; p++) begin
				m0_s2[e][p] <= ex_s1[e] * ry_s1[e][p];
				m1_s2[e][p] <= ey_s1[e] * rx_s1[e][p];
			end
		shared_s2 <= shared_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// final subtract and sign, regrouped as [triangle][edge][point]
	always_comb begin
		logic signed [OW-1:0] d;
		for (int e = 0; e < 6; e++)
			for (int p = 0; p < 6; p++) begin
				d = OW'(m0_s2[e][p]) - OW'(m1_s2[e][p]);
				sgn[e/3][e%3][p].neg = d[OW-1];
				sgn[e/3][e%3][p].pos = !d[OW-1] && (d != '0);
			end
	end

	assign vld_o  = vld_s2;
	assign shared = shared_s2;

endmodule

@@ sv/tpic_classify.sv @@
// Turns orientation signs into the three flags, registered as stage 3.
module tpic_classify import tpic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  tpic_sign_t sgn [2][3][6],
	input  logic       shared,
	output logic       vld_o,
	output tpic_out_t  res
);

	logic      vld_s3;
	tpic_out_t res_s3;
	tpic_out_t nxt;

	always_comb begin
		logic in_ok, out_ok, sep;
		int   oth, i2, j2;
		nxt = '0;
		nxt.common_vertex = shared;
		// closed point-in-triangle tests
		for (int t = 0; t < 2; t++)
			for (int q = 0; q < 3; q++) begin
				oth = (1 - t) * 3 + q;
				in_ok = !sgn[t][0][oth].neg && !sgn[t][1][oth].neg && !sgn[t][2][oth].neg;
				out_ok = !sgn[t][0][oth].pos && !sgn[t][1][oth].pos && !sgn[t][2][oth].pos;
				if (in_ok || out_ok)
					nxt.meets = 1'b1;
			end
		// proper edge crossings
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				i2 = (i + 1) % 3;
				j2 = (j + 1) % 3;
				if (((sgn[0][i][3+j].pos && sgn[0][i][3+j2].neg) ||
				     (sgn[0][i][3+j].neg && sgn[0][i][3+j2].pos)) &&
				    ((sgn[1][j][i].pos && sgn[1][j][i2].neg) ||
				     (sgn[1][j][i].neg && sgn[1][j][i2].pos)))
					nxt.meets = 1'b1;
			end
		// separating edge lines
		for (int t = 0; t < 2; t++)
			for (int e = 0; e < 3; e++) begin
				sep = 1'b1;
				for (int q = 0; q < 3; q++) begin
					oth = (1 - t) * 3 + q;
					if ((sgn[t][e][t*3 + (e+2)%3].pos && sgn[t][e][oth].pos) ||
					    (sgn[t][e][t*3 + (e+2)%3].neg && sgn[t][e][oth].neg))
						sep = 1'b0;
				end
				if (sep)
					nxt.interiors_apart = 1'b1;
			end
	end

	always_ff @(posedge clk) begin
		res_s3 <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld;
		end
	end

	assign vld_o = vld_s3;
	assign res   = res_s3;

endmodule

@@ sv/triangle_pair_intersect_classify_top.sv @@
// Triangle pair classifier, three-stage pipeline.
// done follows start through the valid registers of stages 1, 2 and 3; throughput one pair per cycle.
// busy is always low; the receiver cannot stall, so nothing backs up.
// Reset (arst_n low) clears the stage valid bits; no transaction in flight.
module triangle_pair_intersect_classify_top import tpic_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  tpic_in_t  din,
	output logic      done,
	output tpic_out_t dout
);

	logic [CoordBits-1:0] px [6];
	logic [CoordBits-1:0] py [6];
	tpic_sign_t           sgn [2][3][6];
	logic                 vld_o, shared;

	// coordinates in vertex order, first triangle then second
	assign px[0] = din.first_x0;
	assign py[0] = din.first_y0;
	assign px[1] = din.first_x1;
	assign py[1] = din.first_y1;
	assign px[2] = din.first_x2;
	assign py[2] = din.first_y2;
	assign px[3] = din.second_x0;
	assign py[3] = din.second_y0;
	assign px[4] = din.second_x1;
	assign py[4] = din.second_y1;
	assign px[5] = din.second_x2;
	assign py[5] = din.second_y2;

	assign busy = 1'b0;

	tpic_orient u_orient (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start),
		.px     (px),
		.py     (py),
		.vld_o  (vld_o),
		.sgn    (sgn),
		.shared (shared)
	);

	tpic_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_o),
		.sgn    (sgn),
		.shared (shared),
		.vld_o  (done),
		.res    (dout)
	);

endmodule
